// ===== sv/lfu_slot_table_macros.svh =====
// assertion macros for the lfu slot table checker
// included by the checker file, no other dependencies
`ifndef LFU_SLOT_TABLE_MACROS_SVH
`define LFU_SLOT_TABLE_MACROS_SVH

// same-cycle implication, disabled while reset is asserted
`define LFU_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication, disabled while reset is asserted
`define LFU_ASSERT_NXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== sv/lfu_pkg.sv =====
// shared codes, widths and the config control struct of the lfu slot table
// no dependencies
`timescale 1ns / 1ps

package lfu_pkg;

	localparam int LIMIT_W = 9;
	localparam int ADDR_W  = 3;

	// opcodes
	localparam logic [2:0] OP_ALLOC = 3'd0;
	localparam logic [2:0] OP_RSTAT = 3'd1;
	localparam logic [2:0] OP_INCR  = 3'd2;
	localparam logic [2:0] OP_MARK  = 3'd3;
	localparam logic [2:0] OP_REL   = 3'd4;
	localparam logic [2:0] OP_FMIN  = 3'd5;

	// result status
	localparam logic [1:0] STAT_OK       = 2'd0;
	localparam logic [1:0] STAT_INVALID  = 2'd1;
	localparam logic [1:0] STAT_NOSPACE  = 2'd2;
	localparam logic [1:0] STAT_NOTFOUND = 2'd3;

	// register index, taken from paddr bit 2
	localparam logic REG_LIMIT = 1'b0;

	typedef struct packed {
		logic               clr;
		logic [LIMIT_W-1:0] wr_limit;
		logic [LIMIT_W-1:0] limit;
	} cfg_ctl_t;

endpackage

// ===== sv/lfu_mem.sv =====
// slot entry memory: one write port, one read port, registered read data
// no dependencies
`timescale 1ns / 1ps

module lfu_mem #(
	parameter int DEPTH = 256,
	parameter int WIDTH = 33,
	parameter int AW    = 8
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata_q <= mem[raddr];
	end

	assign rdata = rdata_q;

endmodule

// ===== sv/lfu_cfg.sv =====
// apb slave holding the slot limit register
// depends on lfu_pkg
`timescale 1ns / 1ps

module lfu_cfg #(
	parameter int SLOTS = 256
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        psel,
	input  logic                        penable,
	input  logic                        pwrite,
	input  logic [lfu_pkg::ADDR_W-1:0]  paddr,
	input  logic [31:0]                 pwdata,
	output logic [31:0]                 prdata,
	output logic                        pready,
	output lfu_pkg::cfg_ctl_t           ctl
);

	localparam int LW      = lfu_pkg::LIMIT_W;
	localparam int RST_LIM = (SLOTS < 256) ? SLOTS : 256;

	logic [LW-1:0] limit_q;
	logic [LW-1:0] raw;
	logic [LW-1:0] wr_val;
	logic          wr_en;

	assign pready = 1'b1;
	assign wr_en  = psel && penable && pwrite && (paddr[2] == lfu_pkg::REG_LIMIT);
	assign raw    = pwdata[LW-1:0];

	// zero means one, anything above the table size saturates
	always_comb begin
		wr_val = raw;
		if (raw == '0) begin
			wr_val = LW'(1);
		end else if ({23'b0, raw} > 32'(SLOTS)) begin
			wr_val = LW'(SLOTS);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			limit_q <= LW'(RST_LIM);
		end else if (wr_en) begin
			limit_q <= wr_val;
		end
	end

	assign prdata = (paddr[2] == lfu_pkg::REG_LIMIT) ? {23'b0, limit_q} : 32'b0;

	assign ctl.clr      = wr_en;
	assign ctl.wr_limit = wr_val;
	assign ctl.limit    = limit_q;

endmodule

// ===== sv/lfu_slot_table.sv =====
// lfu slot table top: sequencer, read-modify-write of slot entries, result register
// depends on lfu_pkg, lfu_mem, lfu_cfg
`timescale 1ns / 1ps
//
// channel  | signals                                   | handshake
// ---------+-------------------------------------------+------------------------------
// request  | opcode, slot_id                           | start && !busy
// result   | status, result_slot, was_used             | done, one cycle, no stall
// config   | psel penable pwrite paddr pwdata prdata   | apb, pready tied high
//
// single-slot ops read the entry, then write it back where the op changes it, busy in
// the access state; the result is registered. rejected requests answer the next cycle.
// allocate and find-minimum stream the memory one entry per cycle from its read
// port. after reset and after each limit write a clearing pass writes every
// entry, busy all along.
// results are registered and cannot be stalled.

module lfu_slot_table #(
	parameter int SLOTS      = 256,
	parameter int COUNT_BITS = 32
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        start,
	output logic                        busy,
	input  logic [2:0]                  opcode,
	input  logic [7:0]                  slot_id,
	output logic                        done,
	output logic [1:0]                  status,
	output logic [7:0]                  result_slot,
	output logic                        was_used,
	input  logic                        psel,
	input  logic                        penable,
	input  logic                        pwrite,
	input  logic [lfu_pkg::ADDR_W-1:0]  paddr,
	input  logic [31:0]                 pwdata,
	output logic [31:0]                 prdata,
	output logic                        pready
);

	localparam int LW      = lfu_pkg::LIMIT_W;
	localparam int LIM_MAX = (SLOTS < 511) ? SLOTS : 511;
	localparam int IW      = $clog2(LIM_MAX);
	localparam int DW      = COUNT_BITS + 1;
	localparam int RST_LIM = (SLOTS < 256) ? SLOTS : 256;

	localparam logic [1:0] S_IDLE  = 2'd0;
	localparam logic [1:0] S_CLEAR = 2'd1;
	localparam logic [1:0] S_ACC   = 2'd2;
	localparam logic [1:0] S_SCAN  = 2'd3;

	typedef logic [IW-1:0] idx_t;

	lfu_pkg::cfg_ctl_t ctl;

	logic [1:0]            state_q;
	logic [2:0]            op_q;
	idx_t                  id_q;
	idx_t                  tail_q;
	logic [LW-1:0]         total_q;
	idx_t                  clr_idx_q;
	idx_t                  rd_idx_q;
	logic [LW-1:0]         iss_q;
	logic [LW-1:0]         chk_cnt_q;
	logic                  chk_vld_s1;
	idx_t                  chk_idx_s1;
	logic                  found_q;
	logic [COUNT_BITS-1:0] best_q;
	idx_t                  best_idx_q;
	logic                  done_q;
	logic [1:0]            status_q;
	logic [7:0]            slot_q;
	logic                  was_q;

	logic [LW-1:0]         limit;
	logic                  accept;
	logic                  in_range;
	idx_t                  tail_nx;
	idx_t                  rd_addr;
	logic [DW-1:0]         rdata;
	logic                  rd_used;
	logic [COUNT_BITS-1:0] rd_cnt;
	logic                  scan_last;

	logic                  mem_we;
	idx_t                  mem_waddr;
	logic [DW-1:0]         mem_wdata;
	logic                  res_fire;
	logic [1:0]            res_status;
	logic [7:0]            res_slot;
	logic                  res_was;
	logic                  tot_inc;
	logic                  tot_dec;
	logic                  tail_ld;
	logic                  better;
	logic                  fnd_n;
	idx_t                  bidx_n;

	function automatic idx_t idx_inc(input idx_t i, input logic [LW-1:0] lim);
		idx_t r;
		if (LW'(i) + LW'(1) == lim) begin
			r = '0;
		end else begin
			r = i + IW'(1);
		end
		return r;
	endfunction

	lfu_cfg #(
		.SLOTS (SLOTS)
	) u_cfg (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.ctl     (ctl)
	);

	lfu_mem #(
		.DEPTH (LIM_MAX),
		.WIDTH (DW),
		.AW    (IW)
	) u_mem (
		.clk   (clk),
		.we    (mem_we),
		.waddr (mem_waddr),
		.wdata (mem_wdata),
		.raddr (rd_addr),
		.rdata (rdata)
	);

	assign limit     = ctl.limit;
	assign busy      = (state_q != S_IDLE);
	assign accept    = start && !busy;
	assign in_range  = {1'b0, slot_id} < limit;
	assign tail_nx   = idx_inc(tail_q, limit);
	assign rd_used   = rdata[DW-1];
	assign rd_cnt    = rdata[COUNT_BITS-1:0];
	assign scan_last = (chk_cnt_q == limit - LW'(1));

	always_comb begin
		rd_addr = rd_idx_q;
		if (state_q == S_IDLE) begin
			if (opcode == lfu_pkg::OP_ALLOC) begin
				rd_addr = tail_nx;
			end else if (opcode == lfu_pkg::OP_FMIN) begin
				rd_addr = '0;
			end else begin
				rd_addr = IW'(slot_id);
			end
		end
	end

	always_comb begin
		mem_we     = 1'b0;
		mem_waddr  = chk_idx_s1;
		mem_wdata  = '0;
		res_fire   = 1'b0;
		res_status = lfu_pkg::STAT_OK;
		res_slot   = '0;
		res_was    = 1'b0;
		tot_inc    = 1'b0;
		tot_dec    = 1'b0;
		tail_ld    = 1'b0;
		better     = 1'b0;
		fnd_n      = found_q;
		bidx_n     = best_idx_q;
		case (state_q)
			S_IDLE: begin
				if (accept) begin
					case (opcode)
						lfu_pkg::OP_ALLOC: begin
							if (total_q >= limit) begin
								res_fire   = 1'b1;
								res_status = lfu_pkg::STAT_NOSPACE;
							end
						end
						lfu_pkg::OP_FMIN: begin
							res_fire = 1'b0;
						end
						lfu_pkg::OP_RSTAT, lfu_pkg::OP_INCR,
						lfu_pkg::OP_MARK, lfu_pkg::OP_REL: begin
							if (!in_range) begin
								res_fire   = 1'b1;
								res_status = lfu_pkg::STAT_INVALID;
							end
						end
						default: begin
							res_fire   = 1'b1;
							res_status = lfu_pkg::STAT_INVALID;
						end
					endcase
				end
			end
			S_CLEAR: begin
				mem_we    = 1'b1;
				mem_waddr = clr_idx_q;
			end
			S_ACC: begin
				res_fire  = 1'b1;
				res_was   = rd_used;
				mem_waddr = id_q;
				case (op_q)
					lfu_pkg::OP_RSTAT: begin
						mem_we    = 1'b1;
						mem_wdata = {1'b1, {COUNT_BITS{1'b0}}};
						tot_inc   = !rd_used;
					end
					lfu_pkg::OP_INCR: begin
						if (!rd_used) begin
							res_status = lfu_pkg::STAT_INVALID;
						end else begin
							mem_we    = 1'b1;
							mem_wdata = {1'b1, (&rd_cnt) ? rd_cnt : rd_cnt + COUNT_BITS'(1)};
						end
					end
					lfu_pkg::OP_MARK: begin
						if (!rd_used) begin
							res_status = lfu_pkg::STAT_INVALID;
						end else if (total_q >= limit) begin
							res_status = lfu_pkg::STAT_NOSPACE;
						end else if (id_q != tail_nx) begin
							res_status = lfu_pkg::STAT_INVALID;
						end else begin
							tail_ld = 1'b1;
						end
					end
					lfu_pkg::OP_REL: begin
						mem_we  = 1'b1;
						tot_dec = rd_used;
					end
					default: begin
						res_status = lfu_pkg::STAT_INVALID;
					end
				endcase
			end
			S_SCAN: begin
				if (chk_vld_s1) begin
					if (op_q == lfu_pkg::OP_ALLOC) begin
						if (!rd_used) begin
							mem_we    = 1'b1;
							mem_wdata = {1'b1, {COUNT_BITS{1'b0}}};
							tot_inc   = 1'b1;
							res_fire  = 1'b1;
							res_slot  = 8'(chk_idx_s1);
						end else if (scan_last) begin
							res_fire   = 1'b1;
							res_status = lfu_pkg::STAT_NOSPACE;
						end
					end else begin
						// strict less keeps the lowest index on ties
						better = rd_used && (!found_q || rd_cnt < best_q);
						fnd_n  = found_q || rd_used;
						bidx_n = better ? chk_idx_s1 : best_idx_q;
						if (scan_last) begin
							res_fire   = 1'b1;
							res_status = fnd_n ? lfu_pkg::STAT_OK : lfu_pkg::STAT_NOTFOUND;
							res_slot   = fnd_n ? 8'(bidx_n) : 8'd0;
						end
					end
				end
			end
			default: begin
				res_fire = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= S_CLEAR;
			clr_idx_q  <= '0;
			tail_q     <= IW'(RST_LIM - 1);
			total_q    <= '0;
			done_q     <= 1'b0;
			rd_idx_q   <= '0;
			iss_q      <= '0;
			chk_cnt_q  <= '0;
			chk_vld_s1 <= 1'b0;
			found_q    <= 1'b0;
		end else if (ctl.clr) begin
			state_q    <= S_CLEAR;
			clr_idx_q  <= '0;
			tail_q     <= IW'(ctl.wr_limit - LW'(1));
			total_q    <= '0;
			done_q     <= 1'b0;
			chk_vld_s1 <= 1'b0;
		end else begin
			done_q <= res_fire;
			if (tot_inc) begin
				total_q <= total_q + LW'(1);
			end else if (tot_dec) begin
				total_q <= total_q - LW'(1);
			end
			if (tail_ld) begin
				tail_q <= id_q;
			end
			case (state_q)
				S_IDLE: begin
					if (accept && !res_fire) begin
						if (opcode == lfu_pkg::OP_ALLOC || opcode == lfu_pkg::OP_FMIN) begin
							state_q <= S_SCAN;
						end else begin
							state_q <= S_ACC;
						end
						rd_idx_q   <= idx_inc(rd_addr, limit);
						iss_q      <= LW'(1);
						chk_cnt_q  <= '0;
						chk_vld_s1 <= 1'b1;
						found_q    <= 1'b0;
					end
				end
				S_CLEAR: begin
					clr_idx_q <= clr_idx_q + IW'(1);
					if (clr_idx_q == IW'(LIM_MAX - 1)) begin
						state_q <= S_IDLE;
					end
				end
				S_ACC: begin
					state_q <= S_IDLE;
				end
				S_SCAN: begin
					if (iss_q != limit) begin
						chk_vld_s1 <= 1'b1;
						rd_idx_q   <= idx_inc(rd_idx_q, limit);
						iss_q      <= iss_q + LW'(1);
					end else begin
						chk_vld_s1 <= 1'b0;
					end
					if (chk_vld_s1) begin
						chk_cnt_q <= chk_cnt_q + LW'(1);
						found_q   <= fnd_n;
					end
					if (res_fire) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// request payload, scan pipeline data and result register
	always_ff @(posedge clk) begin
		if (accept) begin
			op_q <= opcode;
			id_q <= IW'(slot_id);
		end
		chk_idx_s1 <= rd_addr;
		if (better) begin
			best_q <= rd_cnt;
		end
		best_idx_q <= bidx_n;
		if (res_fire) begin
			status_q <= res_status;
			slot_q   <= res_slot;
			was_q    <= res_was;
		end
	end

	assign done        = done_q;
	assign status      = status_q;
	assign result_slot = slot_q;
	assign was_used    = was_q;

endmodule

// ===== sv/lfu_slot_table_chk.sv =====
// port-level checker for the lfu slot table, bound to the top level
// depends on lfu_pkg and lfu_slot_table_macros.svh
`timescale 1ns / 1ps
`include "lfu_slot_table_macros.svh"

module lfu_slot_table_chk (
	input logic                        clk,
	input logic                        arst_n,
	input logic                        start,
	input logic                        busy,
	input logic                        done,
	input logic [1:0]                  status,
	input logic [7:0]                  result_slot,
	input logic                        was_used,
	input logic                        psel,
	input logic                        penable,
	input logic                        pwrite,
	input logic [lfu_pkg::ADDR_W-1:0]  paddr
);

	logic cfg_wr;

	assign cfg_wr = psel && penable && pwrite && (paddr[2] == lfu_pkg::REG_LIMIT);

	// every result traces back to a request taken or to work in progress
	`LFU_ASSERT_IMP(a_done_cause, clk, arst_n, done, $past(start && !busy) || $past(busy), "result without request")

	// failed results carry no slot
	`LFU_ASSERT_IMP(a_fail_slot, clk, arst_n, done && status != lfu_pkg::STAT_OK, result_slot == 8'd0, "slot on failed result")

	// not-found results of find-minimum never report a used mark
	`LFU_ASSERT_IMP(a_was_notfound, clk, arst_n, done && was_used, status != lfu_pkg::STAT_NOTFOUND, "used mark on not-found result")

	// a limit write starts the clearing pass and drops any result
	`LFU_ASSERT_NXT(a_cfg_clear, clk, arst_n, cfg_wr, busy && !done, "limit write did not start clear")

endmodule

bind lfu_slot_table lfu_slot_table_chk u_chk (.*);

// ===== verif/tb_lfu_slot_table.sv =====
// self-checking testbench for lfu_slot_table: directed and random slot requests
// over several slot limits, each reply checked against a shadow of the slot table
// depends on lfu_pkg and lfu_slot_table
`timescale 1ns / 1ps

module tb_lfu_slot_table;

	localparam int NUM_SLOTS = 256;
	localparam logic [2:0] OP_UNDEF_A = 3'd6;
	localparam logic [2:0] OP_UNDEF_B = 3'd7;
	localparam logic [lfu_pkg::ADDR_W-1:0] LIMIT_ADDR = {lfu_pkg::REG_LIMIT, 2'b00};

	typedef struct packed {
		logic [1:0] status;
		logic [7:0] slot;
		logic       was_used;
	} slot_reply_t;

	// shadow copy of the slot table, predicts one reply per accepted request
	class slot_table_shadow;
		bit               in_use [NUM_SLOTS];
		logic [31:0]      hits [NUM_SLOTS];
		int unsigned      tail;
		int unsigned      total;
		int unsigned      limit;
		slot_reply_t      pending [$];
		int unsigned      mismatches;
		int unsigned      compared;

		function void clear_slots();
			for (int i = 0; i < NUM_SLOTS; i++) begin
				in_use[i] = 1'b0;
				hits[i] = '0;
			end
			total = 0;
			tail = limit - 1;
		endfunction

		function void take_limit(logic [31:0] wdata);
			int unsigned v;
			v = 32'(wdata[lfu_pkg::LIMIT_W-1:0]);
			if (v == 0)
				v = 1;
			if (v > NUM_SLOTS)
				v = NUM_SLOTS;
			limit = v;
			clear_slots();
		endfunction

		function void take_request(logic [2:0] op, logic [7:0] id);
			slot_reply_t r;
			bit          in_range;
			bit          found;
			int unsigned cand;
			int unsigned best_id;
			logic [31:0] best;
			r = '{status: lfu_pkg::STAT_OK, slot: 8'd0, was_used: 1'b0};
			in_range = (id < limit);
			found = 1'b0;
			cand = 0;
			best_id = 0;
			best = '0;
			if (op >= lfu_pkg::OP_RSTAT && op <= lfu_pkg::OP_REL && in_range)
				r.was_used = in_use[id];
			case (op)
				lfu_pkg::OP_ALLOC: begin
					if (total < limit) begin
						for (int unsigned i = 0; i < limit && !found; i++) begin
							cand = (tail + 1 + i) % limit;
							if (!in_use[cand])
								found = 1'b1;
						end
					end
					if (found) begin
						hits[cand] = '0;
						in_use[cand] = 1'b1;
						total++;
						r.slot = 8'(cand);
					end else begin
						r.status = lfu_pkg::STAT_NOSPACE;
					end
				end
				lfu_pkg::OP_RSTAT: begin
					if (!in_range) begin
						r.status = lfu_pkg::STAT_INVALID;
					end else begin
						hits[id] = '0;
						if (!in_use[id])
							total++;
						in_use[id] = 1'b1;
					end
				end
				lfu_pkg::OP_INCR: begin
					if (!in_range || !in_use[id])
						r.status = lfu_pkg::STAT_INVALID;
					else if (hits[id] != '1)
						hits[id]++;
				end
				lfu_pkg::OP_MARK: begin
					if (!in_range || !in_use[id])
						r.status = lfu_pkg::STAT_INVALID;
					else if (total >= limit)
						r.status = lfu_pkg::STAT_NOSPACE;
					else if (id != (tail + 1) % limit)
						r.status = lfu_pkg::STAT_INVALID;
					else
						tail = 32'(id);
				end
				lfu_pkg::OP_REL: begin
					if (!in_range) begin
						r.status = lfu_pkg::STAT_INVALID;
					end else begin
						if (in_use[id])
							total--;
						in_use[id] = 1'b0;
						hits[id] = '0;
					end
				end
				lfu_pkg::OP_FMIN: begin
					for (int unsigned i = 0; i < limit; i++) begin
						if (in_use[i] && (!found || hits[i] < best)) begin
							best = hits[i];
							best_id = i;
							found = 1'b1;
						end
					end
					if (found)
						r.slot = 8'(best_id);
					else
						r.status = lfu_pkg::STAT_NOTFOUND;
				end
				default: r.status = lfu_pkg::STAT_INVALID;
			endcase
			pending.push_back(r);
		endfunction

		function void check_reply(logic [1:0] st, logic [7:0] slot, logic wu);
			slot_reply_t want;
			if (pending.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("unexpected reply: status %0d slot %0d was_used %0d",
						st, slot, wu);
				return;
			end
			want = pending.pop_front();
			compared++;
			if (st !== want.status || slot !== want.slot || wu !== want.was_used) begin
				mismatches++;
				if (mismatches <= 10)
					$display("reply %0d: status exp %0d got %0d, slot exp %0d got %0d, %s",
						compared, want.status, st, want.slot, slot,
						$sformatf("was_used exp %0d got %0d", want.was_used, wu));
			end
		endfunction
	endclass

	logic                         clk;
	logic                         arst_n = 1'b0;
	logic                         start = 1'b0;
	logic                         busy;
	logic [2:0]                   opcode = lfu_pkg::OP_ALLOC;
	logic [7:0]                   slot_id = 8'd0;
	logic                         done;
	logic [1:0]                   status;
	logic [7:0]                   result_slot;
	logic                         was_used;
	logic                         psel = 1'b0;
	logic                         penable = 1'b0;
	logic                         pwrite = 1'b0;
	logic [lfu_pkg::ADDR_W-1:0]   paddr = '0;
	logic [31:0]                  pwdata = '0;
	logic [31:0]                  prdata;
	logic                         pready;

	slot_table_shadow shadow = new();
	int unsigned      gap_pct = 0;
	int unsigned      requests = 0;
	int unsigned      settings = 0;

	lfu_slot_table i_dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.start      (start),
		.busy       (busy),
		.opcode     (opcode),
		.slot_id    (slot_id),
		.done       (done),
		.status     (status),
		.result_slot(result_slot),
		.was_used   (was_used),
		.psel       (psel),
		.penable    (penable),
		.pwrite     (pwrite),
		.paddr      (paddr),
		.pwdata     (pwdata),
		.prdata     (prdata),
		.pready     (pready)
	);

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	always @(posedge clk) begin
		if (arst_n && done === 1'b1)
			shadow.check_reply(status, result_slot, was_used);
	end

	// called just after posedge clk; start stays high when no gap is taken
	task automatic issue(input logic [2:0] op, input logic [7:0] id);
		if ($urandom_range(0, 99) < gap_pct) begin
			start <= 1'b0;
			if ($urandom_range(0, 7) == 0)
				repeat ($urandom_range(1, 40)) @(posedge clk);
			else
				repeat ($urandom_range(1, 5)) @(posedge clk);
		end
		start <= 1'b1;
		opcode <= op;
		slot_id <= id;
		do @(posedge clk); while (busy !== 1'b0);
		shadow.take_request(op, id);
		requests++;
	endtask

	task automatic write_limit(input logic [31:0] value);
		int unsigned guard;
		guard = 0;
		start <= 1'b0;
		while (shadow.pending.size() != 0 && guard < 5000) begin
			@(posedge clk);
			guard++;
		end
		repeat (4) @(posedge clk);
		psel <= 1'b1;
		pwrite <= 1'b1;
		penable <= 1'b0;
		paddr <= LIMIT_ADDR;
		pwdata <= value;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (pready !== 1'b1);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		shadow.take_limit(value);
		settings++;
	endtask

	function automatic logic [7:0] pick_slot();
		if ($urandom_range(0, 9) < 8)
			return 8'($urandom_range(0, shadow.limit - 1));
		return 8'($urandom_range(0, 255));
	endfunction

	function automatic logic [7:0] pick_used();
		int unsigned first;
		int unsigned c;
		first = $urandom_range(0, shadow.limit - 1);
		for (int unsigned i = 0; i < shadow.limit; i++) begin
			c = (first + i) % shadow.limit;
			if (shadow.in_use[c])
				return 8'(c);
		end
		return pick_slot();
	endfunction

	// find-min, increment, allocate, in-order mark weigh most so the table fills and ages
	task automatic random_requests(input int unsigned count);
		logic [2:0]  op;
		logic [7:0]  id;
		int unsigned roll;
		for (int unsigned k = 0; k < count; k++) begin
			roll = $urandom_range(0, 99);
			id = pick_slot();
			if (roll < 18) begin
				op = lfu_pkg::OP_ALLOC;
			end else if (roll < 27) begin
				op = lfu_pkg::OP_RSTAT;
			end else if (roll < 48) begin
				op = lfu_pkg::OP_INCR;
				if ($urandom_range(0, 4) != 0)
					id = pick_used();
			end else if (roll < 62) begin
				op = lfu_pkg::OP_MARK;
				if ($urandom_range(0, 3) != 0)
					id = 8'((shadow.tail + 1) % shadow.limit);
			end else if (roll < 74) begin
				op = lfu_pkg::OP_REL;
				if ($urandom_range(0, 1) != 0)
					id = pick_used();
			end else if (roll < 96) begin
				op = lfu_pkg::OP_FMIN;
			end else begin
				op = ($urandom_range(0, 1) != 0) ? OP_UNDEF_A : OP_UNDEF_B;
			end
			issue(op, id);
		end
	endtask

	logic [31:0] limit_plan [8] = '{32'hFFFF_FE00, 32'd2, 32'd3, 32'd300,
		32'd8, 32'd16, 32'd256, 32'd0};

	initial begin
		int unsigned guard;
		shadow.take_limit(32'd256);
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed, default limit of 256
		gap_pct = 31;
		issue(lfu_pkg::OP_FMIN, 8'd0);
		issue(lfu_pkg::OP_ALLOC, 8'd0);
		issue(lfu_pkg::OP_ALLOC, 8'd77);
		issue(lfu_pkg::OP_FMIN, 8'd0);
		issue(lfu_pkg::OP_INCR, 8'd0);
		issue(lfu_pkg::OP_FMIN, 8'd255);
		issue(lfu_pkg::OP_MARK, 8'd0);
		issue(lfu_pkg::OP_MARK, 8'd2);
		issue(lfu_pkg::OP_MARK, 8'd0);
		issue(lfu_pkg::OP_MARK, 8'd1);
		issue(lfu_pkg::OP_INCR, 8'd5);
		issue(lfu_pkg::OP_RSTAT, 8'd255);
		issue(lfu_pkg::OP_RSTAT, 8'd255);
		issue(lfu_pkg::OP_REL, 8'd255);
		issue(lfu_pkg::OP_REL, 8'd255);
		issue(OP_UNDEF_A, 8'd1);
		issue(OP_UNDEF_B, 8'd170);

		// single slot: out of range ids and a full table
		write_limit(32'd1);
		issue(lfu_pkg::OP_RSTAT, 8'd1);
		issue(lfu_pkg::OP_ALLOC, 8'd0);
		issue(lfu_pkg::OP_ALLOC, 8'd0);
		issue(lfu_pkg::OP_MARK, 8'd0);
		issue(lfu_pkg::OP_FMIN, 8'd0);
		issue(lfu_pkg::OP_REL, 8'd0);
		issue(lfu_pkg::OP_INCR, 8'd255);

		for (int p = 0; p < 8; p++) begin
			gap_pct = (p < 3) ? 31 : ((p < 6) ? 81 : 0);
			write_limit((p == 7) ? $urandom_range(1, NUM_SLOTS) : limit_plan[p]);
			random_requests(106);
		end
		start <= 1'b0;

		guard = 0;
		while (shadow.pending.size() != 0 && guard < 5000) begin
			@(posedge clk);
			guard++;
		end
		repeat (20) @(posedge clk);

		$display("%0d requests under %0d slot limits (1 to 256, zero and oversize writes)",
			requests, settings);
		$display("%0d replies compared, %0d mismatches, %0d replies missing",
			shadow.compared, shadow.mismatches, shadow.pending.size());
		if (shadow.mismatches == 0 && shadow.pending.size() == 0) begin
			$display("ALL CHECKS PASSED");
		end else begin
			$display("CHECKS FAILED");
		end
		$finish;
	end

	initial begin
		#20_000_000;
		$display("timeout");
		$display("CHECKS FAILED");
		$finish;
	end

endmodule

// ===== files.f =====
+incdir+sv
sv/lfu_pkg.sv
sv/lfu_mem.sv
sv/lfu_cfg.sv
sv/lfu_slot_table.sv
sv/lfu_slot_table_chk.sv
verif/tb_lfu_slot_table.sv
